>>> design/q2rm_pkg.sv
// ============================================================================
// q2rm_pkg: shared types and constants for the quaternion to matrix block
// Holds the request and result structs and the datapath widths.
// ============================================================================
package q2rm_pkg;

    // Quotient bits of one element magnitude (0..16384).
    localparam int Q_W     = 15;
    // Width of the squared norm n (at most 2^32).
    localparam int N_W     = 33;
    // Width of the divisor 2n.
    localparam int D_W     = N_W + 1;
    // Width of the partial remainder: mag * 2^15 + n.
    localparam int REM_W   = N_W + Q_W;
    // Width of a signed element numerator (|num| <= n).
    localparam int NUM_W   = N_W + 2;
    // Number of matrix elements.
    localparam int N_ELEM  = 9;
    // Divider pipeline: one setup stage plus one stage per quotient bit.
    localparam int DIV_LAT = Q_W + 1;
    // Request to result strobe, in cycles.
    localparam int LAT     = DIV_LAT + 3;

    localparam logic [15:0] ONE_Q14 = 16'sd16384;

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } t_quat;

    typedef struct packed {
        logic signed [15:0] elem_00;
        logic signed [15:0] elem_01;
        logic signed [15:0] elem_02;
        logic signed [15:0] elem_10;
        logic signed [15:0] elem_11;
        logic signed [15:0] elem_12;
        logic signed [15:0] elem_20;
        logic signed [15:0] elem_21;
        logic signed [15:0] elem_22;
        logic               zero_quat;
    } t_matrix;

    // Side information that travels alongside the divider lanes.
    typedef struct packed {
        logic [N_ELEM-1:0] neg;
        logic              zero;
    } t_side;

endpackage

>>> design/quaternion_to_rotation_matrix.sv
// ============================================================================
// quaternion_to_rotation_matrix: quaternion to normalized 3x3 rotation matrix
// Fully pipelined; one quaternion per cycle, exact rounded Q1.14 elements.
// ============================================================================
// How to use this block:
// A request is one quaternion on i_quat, taken at a rising edge where start
// is high and busy is low. busy is always low here, so a new request may be
// issued in every cycle with no gaps.
// The result appears on o_result for exactly one cycle, marked by o_valid,
// once the request has passed the product, numerator, divider and output
// registers in that order. Results come out in the order that the requests
// went in, one per request.
// Most of the pipeline is the element divider: the matrix numerators are
// divided by the squared norm with one quotient bit per stage, which takes
// fifteen stages plus one setup stage. Products, the norm and numerators,
// and the final sign and identity selection take one stage each.
// Each element is round(16384 * num / n) with halves away from zero, so
// the norm needs no square root. An all-zero quaternion gives the identity
// matrix with zero_quat set.
// The receiver cannot stall this block, so nothing holds the pipeline.
// Reset clears all valid bits; requests in flight at reset are dropped.
// ============================================================================
module quaternion_to_rotation_matrix (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  q2rm_pkg::t_quat     i_quat,
    output logic                o_valid,
    output q2rm_pkg::t_matrix   o_result
);

    // Valid bits, one per pipeline stage.
    logic [q2rm_pkg::LAT-1:0] r_vld;

    // Stage 1: squares and cross products.
    logic [30:0]        r_xx, r_yy, r_zz, r_ww;
    logic signed [31:0] r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;

    // Stage 2: squared norm and the nine numerators.
    logic [q2rm_pkg::N_W-1:0]          r_n;
    logic signed [q2rm_pkg::NUM_W-1:0] r_num [q2rm_pkg::N_ELEM];
    logic                              r_zero;

    // Side line carrying signs and the zero flag across the divider.
    q2rm_pkg::t_side r_side [q2rm_pkg::DIV_LAT];
    q2rm_pkg::t_side n_side;

    logic [q2rm_pkg::Q_W-1:0] div_q [q2rm_pkg::N_ELEM];

    q2rm_pkg::t_matrix r_res;
    q2rm_pkg::t_matrix n_res;

    // The pipeline never stalls, so a request is always taken.
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[q2rm_pkg::LAT-2:0], start};
        end
    end

    // Stage 1: ten 16x16 signed multiplies. Squares are never negative.
    logic signed [31:0] sq_x, sq_y, sq_z, sq_w;
    always_comb begin
        sq_x = i_quat.quat_x * i_quat.quat_x;
        sq_y = i_quat.quat_y * i_quat.quat_y;
        sq_z = i_quat.quat_z * i_quat.quat_z;
        sq_w = i_quat.quat_w * i_quat.quat_w;
    end

    always_ff @(posedge i_clk) begin
        r_xx <= sq_x[30:0];
        r_yy <= sq_y[30:0];
        r_zz <= sq_z[30:0];
        r_ww <= sq_w[30:0];
        r_xy <= i_quat.quat_x * i_quat.quat_y;
        r_xz <= i_quat.quat_x * i_quat.quat_z;
        r_yz <= i_quat.quat_y * i_quat.quat_z;
        r_wx <= i_quat.quat_w * i_quat.quat_x;
        r_wy <= i_quat.quat_w * i_quat.quat_y;
        r_wz <= i_quat.quat_w * i_quat.quat_z;
    end

    // Stage 2: the diagonal numerators are n - 2(a^2 + b^2), the others are
    // twice a sum or difference of two cross products.
    logic [q2rm_pkg::N_W-1:0]          n_n, s_yz, s_xz, s_xy;
    logic signed [q2rm_pkg::NUM_W-1:0] sn;
    logic signed [q2rm_pkg::NUM_W-1:0] n_num [q2rm_pkg::N_ELEM];

    always_comb begin
        n_n  = q2rm_pkg::N_W'(r_xx) + q2rm_pkg::N_W'(r_yy)
             + q2rm_pkg::N_W'(r_zz) + q2rm_pkg::N_W'(r_ww);
        s_yz = q2rm_pkg::N_W'(r_yy) + q2rm_pkg::N_W'(r_zz);
        s_xz = q2rm_pkg::N_W'(r_xx) + q2rm_pkg::N_W'(r_zz);
        s_xy = q2rm_pkg::N_W'(r_xx) + q2rm_pkg::N_W'(r_yy);
        sn   = $signed({2'b00, n_n});
        n_num[0] = sn - $signed({1'b0, s_yz, 1'b0});
        n_num[1] = (q2rm_pkg::NUM_W'(r_xy) + q2rm_pkg::NUM_W'(r_wz)) <<< 1;
        n_num[2] = (q2rm_pkg::NUM_W'(r_xz) - q2rm_pkg::NUM_W'(r_wy)) <<< 1;
        n_num[3] = (q2rm_pkg::NUM_W'(r_xy) - q2rm_pkg::NUM_W'(r_wz)) <<< 1;
        n_num[4] = sn - $signed({1'b0, s_xz, 1'b0});
        n_num[5] = (q2rm_pkg::NUM_W'(r_yz) + q2rm_pkg::NUM_W'(r_wx)) <<< 1;
        n_num[6] = (q2rm_pkg::NUM_W'(r_xz) + q2rm_pkg::NUM_W'(r_wy)) <<< 1;
        n_num[7] = (q2rm_pkg::NUM_W'(r_yz) - q2rm_pkg::NUM_W'(r_wx)) <<< 1;
        n_num[8] = sn - $signed({1'b0, s_xy, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_num  <= n_num;
        r_zero <= (n_n == '0);
    end

    // Divider lanes work on magnitudes; the signs wait on the side line.
    for (genvar e = 0; e < q2rm_pkg::N_ELEM; e++) begin : g_lane
        logic [q2rm_pkg::NUM_W-1:0] mag_full;

        assign mag_full = r_num[e][q2rm_pkg::NUM_W-1] ? q2rm_pkg::NUM_W'(-r_num[e])
                                                       : q2rm_pkg::NUM_W'(r_num[e]);

        q2rm_divider u_div (
            .i_clk (i_clk),
            .i_mag (mag_full[q2rm_pkg::N_W-1:0]),
            .i_n   (r_n),
            .o_q   (div_q[e])
        );
    end

    always_comb begin
        for (int e = 0; e < q2rm_pkg::N_ELEM; e++) begin
            n_side.neg[e] = r_num[e][q2rm_pkg::NUM_W-1];
        end
        n_side.zero = r_zero;
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= n_side;
        for (int s = 1; s < q2rm_pkg::DIV_LAT; s++) begin
            r_side[s] <= r_side[s-1];
        end
    end

    // Output stage: restore signs, or force the identity for a zero input.
    logic [15:0] el [q2rm_pkg::N_ELEM];
    q2rm_pkg::t_side side_out;

    always_comb begin
        side_out = r_side[q2rm_pkg::DIV_LAT-1];
        for (int e = 0; e < q2rm_pkg::N_ELEM; e++) begin
            el[e] = side_out.neg[e] ? (16'd0 - {1'b0, div_q[e]}) : {1'b0, div_q[e]};
        end
        if (side_out.zero) begin
            n_res = '0;
            n_res.elem_00   = q2rm_pkg::ONE_Q14;
            n_res.elem_11   = q2rm_pkg::ONE_Q14;
            n_res.elem_22   = q2rm_pkg::ONE_Q14;
            n_res.zero_quat = 1'b1;
        end else begin
            n_res.elem_00   = el[0];
            n_res.elem_01   = el[1];
            n_res.elem_02   = el[2];
            n_res.elem_10   = el[3];
            n_res.elem_11   = el[4];
            n_res.elem_12   = el[5];
            n_res.elem_20   = el[6];
            n_res.elem_21   = el[7];
            n_res.elem_22   = el[8];
            n_res.zero_quat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid  = r_vld[q2rm_pkg::LAT-1];
    assign o_result = r_res;

endmodule

>>> design/q2rm_divider.sv
// ============================================================================
// q2rm_divider: pipelined restoring divider for one matrix element
// Computes floor((mag * 2^15 + n) / (2n)), one quotient bit per stage.
// ============================================================================
module q2rm_divider (
    input  logic                       i_clk,
    input  logic [q2rm_pkg::N_W-1:0]   i_mag,
    input  logic [q2rm_pkg::N_W-1:0]   i_n,
    output logic [q2rm_pkg::Q_W-1:0]   o_q
);

    logic [q2rm_pkg::REM_W-1:0] r_rem [q2rm_pkg::Q_W+1];
    logic [q2rm_pkg::D_W-1:0]   r_d   [q2rm_pkg::Q_W+1];
    logic [q2rm_pkg::Q_W-1:0]   r_q   [q2rm_pkg::Q_W+1];

    // Setup stage: adding n before dividing by 2n gives round to nearest.
    always_ff @(posedge i_clk) begin
        r_rem[0] <= (q2rm_pkg::REM_W'(i_mag) << q2rm_pkg::Q_W)
                    + q2rm_pkg::REM_W'(i_n);
        r_d[0]   <= {i_n, 1'b0};
        r_q[0]   <= '0;
    end

    for (genvar k = 1; k <= q2rm_pkg::Q_W; k++) begin : g_stage
        logic [q2rm_pkg::REM_W-1:0] dsh;
        logic                       fit;
        logic [q2rm_pkg::REM_W-1:0] n_rem;
        logic [q2rm_pkg::Q_W-1:0]   n_q;

        always_comb begin
            dsh   = q2rm_pkg::REM_W'(r_d[k-1]) << (q2rm_pkg::Q_W - k);
            fit   = (r_rem[k-1] >= dsh);
            n_rem = fit ? (r_rem[k-1] - dsh) : r_rem[k-1];
            n_q   = r_q[k-1];
            n_q[q2rm_pkg::Q_W - k] = fit;
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= n_rem;
            r_d[k]   <= r_d[k-1];
            r_q[k]   <= n_q;
        end
    end

    assign o_q = r_q[q2rm_pkg::Q_W];

endmodule

>>> design/q2rm_checker.sv
// ============================================================================
// q2rm_checker: port-level checks for the quaternion to matrix block
// Watches request and result strobes and the result payload.
// ============================================================================
module q2rm_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                busy,
    input  q2rm_pkg::t_quat     i_quat,
    input  logic                o_valid,
    input  q2rm_pkg::t_matrix   o_result
);

    // Every taken request produces a result strobe after the fixed latency.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(q2rm_pkg::LAT) o_valid)
        else $error("request did not produce a result on time");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, q2rm_pkg::LAT))
        else $error("result strobe without a matching request");

    // A zero quaternion must yield the identity matrix.
    a_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.zero_quat) |->
            (o_result.elem_00 == q2rm_pkg::ONE_Q14 &&
             o_result.elem_11 == q2rm_pkg::ONE_Q14 &&
             o_result.elem_22 == q2rm_pkg::ONE_Q14 &&
             o_result.elem_01 == '0 && o_result.elem_02 == '0 &&
             o_result.elem_10 == '0 && o_result.elem_12 == '0 &&
             o_result.elem_20 == '0 && o_result.elem_21 == '0))
        else $error("zero quaternion did not give the identity");

    // The zero flag must match the request that produced the result.
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.zero_quat == ($past(i_quat, q2rm_pkg::LAT) == '0)))
        else $error("zero flag does not match the request");

endmodule

bind quaternion_to_rotation_matrix q2rm_checker u_q2rm_checker (.*);
